/* rtl/srg_pkg.sv */
`default_nettype none

package srg_pkg;

   localparam int SLEW_W = 16;
   localparam int FRAC_W = 4;
   localparam int MS_W = 10;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;

   localparam int PROD_W = SLEW_W + MS_W;
   localparam int REM_W = 10;
   localparam int RECIP_W = 17;
   localparam int QUO_W = RECIP_W;

   localparam int MS_PER_SEC = 1000;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << PROD_W) / MS_PER_SEC);

   localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SLEW_RATE = 1'b0,
      CSR_FRAC_BITS = 1'b1
   } csr_idx_type;

endpackage

`default_nettype wire

/* rtl/srg_if.sv */
`default_nettype none

interface srg_req_if
   import srg_pkg::*;
#(
   parameter int TARGET_WIDTH = 17
);
   logic                           valid;
   logic                           ready;
   logic signed [TARGET_WIDTH-1:0] requested_target;
   logic        [MS_W-1:0]         elapsed_ms;

   modport source (output valid, output requested_target, output elapsed_ms, input ready);
   modport sink (input valid, input requested_target, input elapsed_ms, output ready);
endinterface

interface srg_rsp_if #(
   parameter int TARGET_WIDTH = 17,
   parameter int FIXED_WIDTH  = 25
);
   logic                           valid;
   logic                           ready;
   logic signed [FIXED_WIDTH-1:0]  ramped_fixed;
   logic signed [TARGET_WIDTH-1:0] ramped_raw;
   logic                           ramp_active;

   modport source (output valid, output ramped_fixed, output ramped_raw, output ramp_active,
                   input ready);
   modport sink (input valid, input ramped_fixed, input ramped_raw, input ramp_active,
                 output ready);
endinterface

`default_nettype wire

/* rtl/setpoint_ramp_generator_top.sv */
// Request beats enter the stage-one register; results leave the stage-eight register.
// Throughput: one beat per cycle through an eight-register pipeline while the output is
// ready; the ramp state is read and written in stage seven, so consecutive beats never wait on it.
// Reset is synchronous and active high: it empties the pipeline, clears the ramp to
// zero, sets the slew rate to zero and the fractional bits to eight.
`default_nettype none

module setpoint_ramp_generator_top
   import srg_pkg::*;
#(
   parameter int TARGET_WIDTH  = 17,
   parameter int MAX_FRAC_BITS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   srg_req_if.sink              req_chan,
   srg_rsp_if.source            rsp_chan,
   input  wire                  csr_wr_en,
   input  wire [CSR_ADDR_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FW      = TARGET_WIDTH + MAX_FRAC_BITS;
   localparam int T_W     = REM_W + MAX_FRAC_BITS;
   localparam int FQ_W    = T_W + RECIP_W - PROD_W;
   localparam int STEP_W  = QUO_W + MAX_FRAC_BITS;
   localparam int CMP_W   = (STEP_W > FW + 1) ? STEP_W : FW + 1;
   localparam longint RAW_MAX = (longint'(1) << (TARGET_WIDTH - 1)) - 1;

   // Configuration registers.
   logic [SLEW_W-1:0] slew_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [FRAC_W-1:0] fb;

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_ff <= '0;
         frac_ff <= FRAC_RESET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SLEW_RATE: slew_ff <= csr_wdata[SLEW_W-1:0];
            CSR_FRAC_BITS: frac_ff <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   assign fb = (frac_ff > FRAC_W'(MAX_FRAC_BITS)) ? FRAC_W'(MAX_FRAC_BITS) : frac_ff;

   // Stage valids and the ready chain.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;

   assign rdy8 = !v8_ff || rsp_chan.ready;
   assign rdy7 = !v7_ff || rdy8;
   assign rdy6 = !v6_ff || rdy7;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_chan.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_chan.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
         if (rdy7) v7_ff <= v6_ff;
         if (rdy8) v8_ff <= v7_ff;
      end
   end

   // Stage 1: input register.
   logic signed [TARGET_WIDTH-1:0] s1_req_ff;
   logic        [MS_W-1:0]         s1_ms_ff;

   always_ff @(posedge clock) begin
      if (rdy1 && req_chan.valid) begin
         s1_req_ff <= req_chan.requested_target;
         s1_ms_ff  <= req_chan.elapsed_ms;
      end
   end

   // Stage 2: slew times elapsed time, and the request in fixed point.
   logic        [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic signed [FW-1:0]     s2_target_ff, s2_target_in;
   logic                     s2_move_ff;
   logic signed [FW-1:0]     req_ext;

   assign req_ext      = FW'(s1_req_ff);
   assign s2_target_in = req_ext <<< fb;
   assign s2_prod_in   = PROD_W'(slew_ff) * PROD_W'(s1_ms_ff);

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_prod_ff   <= s2_prod_in;
         s2_target_ff <= s2_target_in;
         s2_move_ff   <= (s2_prod_in != '0);
      end
   end

   // Stage 3: estimate of the whole seconds quotient by reciprocal multiplication.
   logic        [PROD_W-1:0]         s3_prod_ff;
   logic        [QUO_W-1:0]          s3_q0_ff;
   logic signed [FW-1:0]             s3_target_ff;
   logic                             s3_move_ff;
   logic        [PROD_W+RECIP_W-1:0] s3_mul_in;

   assign s3_mul_in = (PROD_W + RECIP_W)'(s2_prod_ff) * (PROD_W + RECIP_W)'(RECIP_M);

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_prod_ff   <= s2_prod_ff;
         s3_q0_ff     <= s3_mul_in[PROD_W+RECIP_W-1:PROD_W];
         s3_target_ff <= s2_target_ff;
         s3_move_ff   <= s2_move_ff;
      end
   end

   // Stage 4: remainder and a single correction of the quotient.
   logic        [QUO_W-1:0]  s4_q_ff;
   logic        [REM_W-1:0]  s4_rem_ff;
   logic signed [FW-1:0]     s4_target_ff;
   logic                     s4_move_ff;
   logic        [PROD_W-1:0] s4_rem_full;
   logic                     s4_over;

   assign s4_rem_full = s3_prod_ff - PROD_W'(s3_q0_ff * PROD_W'(MS_PER_SEC));
   assign s4_over     = (s4_rem_full >= PROD_W'(MS_PER_SEC));

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         s4_q_ff      <= s4_over ? s3_q0_ff + QUO_W'(1) : s3_q0_ff;
         s4_rem_ff    <= s4_over ? REM_W'(s4_rem_full - PROD_W'(MS_PER_SEC))
                                 : REM_W'(s4_rem_full);
         s4_target_ff <= s3_target_ff;
         s4_move_ff   <= s3_move_ff;
      end
   end

   // Stage 5: the scaled remainder and the estimate of its quotient.
   logic        [QUO_W-1:0]       s5_q_ff;
   logic        [T_W-1:0]         s5_t_ff;
   logic        [FQ_W-1:0]        s5_q1_ff;
   logic signed [FW-1:0]          s5_target_ff;
   logic                          s5_move_ff;
   logic        [T_W-1:0]         s5_t_in;
   logic        [T_W+RECIP_W-1:0] s5_mul_in;

   assign s5_t_in   = T_W'(s4_rem_ff) << fb;
   assign s5_mul_in = (T_W + RECIP_W)'(s5_t_in) * (T_W + RECIP_W)'(RECIP_M);

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         s5_q_ff      <= s4_q_ff;
         s5_t_ff      <= s5_t_in;
         s5_q1_ff     <= s5_mul_in[T_W+RECIP_W-1:PROD_W];
         s5_target_ff <= s4_target_ff;
         s5_move_ff   <= s4_move_ff;
      end
   end

   // Stage 6: corrected fractional quotient and the assembled step.
   logic        [STEP_W-1:0] s6_step_ff;
   logic signed [FW-1:0]     s6_target_ff;
   logic                     s6_move_ff;
   logic        [T_W-1:0]    s6_r2;
   logic        [FQ_W-1:0]   s6_fq;
   logic        [STEP_W-1:0] s6_step_in;

   assign s6_r2      = s5_t_ff - T_W'(s5_q1_ff * T_W'(MS_PER_SEC));
   assign s6_fq      = (s6_r2 >= T_W'(MS_PER_SEC)) ? s5_q1_ff + FQ_W'(1) : s5_q1_ff;
   assign s6_step_in = (STEP_W'(s5_q_ff) << fb) + STEP_W'(s6_fq);

   always_ff @(posedge clock) begin
      if (rdy6 && v5_ff) begin
         s6_step_ff   <= s6_step_in;
         s6_target_ff <= s5_target_ff;
         s6_move_ff   <= s5_move_ff;
      end
   end

   // Stage 7: ramp state update.
   logic signed [FW-1:0]     state_ff, state_in;
   logic signed [FW-1:0]     s7_fixed_ff;
   logic                     s7_active_ff;
   logic signed [FW:0]       cur_ext, tgt_ext, delta;
   logic        [FW:0]       remain;
   logic        [STEP_W-1:0] step_eff;
   logic signed [FW:0]       moved;

   assign cur_ext  = {state_ff[FW-1], state_ff};
   assign tgt_ext  = {s6_target_ff[FW-1], s6_target_ff};
   assign delta    = tgt_ext - cur_ext;
   assign remain   = delta[FW] ? (FW + 1)'(0) - delta : delta;
   assign step_eff = (s6_step_ff == '0) ? STEP_W'(1) : s6_step_ff;
   assign moved    = delta[FW] ? cur_ext - (FW + 1)'(step_eff) : cur_ext + (FW + 1)'(step_eff);

   always_comb begin
      state_in = state_ff;
      if ((state_ff != s6_target_ff) && s6_move_ff) begin
         if (CMP_W'(step_eff) >= CMP_W'(remain)) begin
            state_in = s6_target_ff;
         end else begin
            state_in = moved[FW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (rdy7 && v6_ff) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy7 && v6_ff) begin
         s7_fixed_ff  <= state_in;
         s7_active_ff <= (state_in != s6_target_ff);
      end
   end

   // Stage 8: rounding to raw units, half away from zero, with saturation.
   logic signed [FW-1:0]           s8_fixed_ff;
   logic signed [TARGET_WIDTH-1:0] s8_raw_ff, s8_raw_in;
   logic                           s8_active_ff;
   logic signed [FW:0]             fx_ext;
   logic        [FW:0]             mag, half, quo;

   assign fx_ext = {s7_fixed_ff[FW-1], s7_fixed_ff};
   assign mag    = fx_ext[FW] ? (FW + 1)'(0) - fx_ext : fx_ext;
   assign half   = (fb == '0) ? '0 : (FW + 1)'(1) << (fb - FRAC_W'(1));
   assign quo    = (mag + half) >> fb;

   always_comb begin
      if (fx_ext[FW]) begin
         if (quo > (FW + 1)'(RAW_MAX + 1)) begin
            s8_raw_in = TARGET_WIDTH'(-(RAW_MAX + 1));
         end else begin
            s8_raw_in = TARGET_WIDTH'((FW + 1)'(0) - quo);
         end
      end else begin
         if (quo > (FW + 1)'(RAW_MAX)) begin
            s8_raw_in = TARGET_WIDTH'(RAW_MAX);
         end else begin
            s8_raw_in = TARGET_WIDTH'(quo);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy8 && v7_ff) begin
         s8_fixed_ff  <= s7_fixed_ff;
         s8_raw_ff    <= s8_raw_in;
         s8_active_ff <= s7_active_ff;
      end
   end

   assign rsp_chan.valid        = v8_ff;
   assign rsp_chan.ramped_fixed = s8_fixed_ff;
   assign rsp_chan.ramped_raw   = s8_raw_ff;
   assign rsp_chan.ramp_active  = s8_active_ff;

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(rdy7 && v6_ff) |=> $stable(state_ff))
      else $error("ramp state changed without a beat in the update stage");

   a_no_move_hold: assert property (@(posedge clock) disable iff (reset)
      (rdy7 && v6_ff && !s6_move_ff) |=> (state_ff == $past(state_ff)))
      else $error("ramp moved with zero slew or zero elapsed time");

   a_land: assert property (@(posedge clock) disable iff (reset)
      (rdy7 && v6_ff && (state_in == s6_target_ff)) |=> !s7_active_ff)
      else $error("ramp flagged active after landing on its target");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (s4_rem_ff < REM_W'(MS_PER_SEC)))
      else $error("seconds remainder out of range after correction");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff && v7_ff && v8_ff
       && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the pipeline is full and stalled");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srg_pkg::*;

   localparam int TGT_W = 17;
   localparam int FRAC_MAX = 8;
   localparam int FIX_W = TGT_W + FRAC_MAX;
   localparam int GAP_MAX = 19;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASES = 12;
   localparam int TICKS_PER_PHASE = 75;
   localparam longint RAW_MIN = -(longint'(1) << (TGT_W - 1));
   localparam longint RAW_MAX = (longint'(1) << (TGT_W - 1)) - 1;

   typedef struct {
      logic signed [TGT_W-1:0] target;
      logic [MS_W-1:0]         ms;
      int unsigned             gap;
   } tick_type;

   typedef struct {
      logic signed [FIX_W-1:0] fixed;
      logic signed [TGT_W-1:0] raw;
      logic                    active;
   } setpoint_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   srg_req_if #(.TARGET_WIDTH(TGT_W)) req_chan ();
   srg_rsp_if #(.TARGET_WIDTH(TGT_W), .FIXED_WIDTH(FIX_W)) rsp_chan ();

   setpoint_ramp_generator_top #(
      .TARGET_WIDTH(TGT_W),
      .MAX_FRAC_BITS(FRAC_MAX)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor state: its own copy of the registers and of the ramp.
   logic [SLEW_W-1:0]       slew_cfg;
   logic [FRAC_W-1:0]       frac_cfg;
   logic signed [FIX_W-1:0] ramp_fx;

   tick_type     tick_q[$];
   tick_type     offered;
   setpoint_type setpoint_q[$];
   int unsigned gap_cnt = 0;
   int unsigned stall_cnt = 0;
   int unsigned stall_goal = 0;
   int unsigned hold_cnt = 0;
   int unsigned hold_token = 0;
   int unsigned hold_seen = 0;
   int unsigned errors = 0;
   int unsigned ticks_sent = 0;
   int unsigned setpoints_seen = 0;
   int unsigned csr_writes = 0;
   bit          snd_idle = 1'b1;
   bit          rsp_idle = 1'b1;

   function automatic setpoint_type next_setpoint(input logic signed [TGT_W-1:0] target,
                                                  input logic [MS_W-1:0] ms);
      int unsigned fb;
      longint goal, cur, nxt, remain, step, mag, rnd, half;
      setpoint_type r;
      fb = (frac_cfg > FRAC_MAX) ? FRAC_MAX : frac_cfg;
      goal = longint'(target) * (longint'(1) << fb);
      cur = longint'(ramp_fx);
      nxt = cur;
      if (cur != goal && slew_cfg != 0 && ms != 0) begin
         remain = (goal > cur) ? goal - cur : cur - goal;
         step = (longint'(slew_cfg) * longint'(ms) * (longint'(1) << fb)) / MS_PER_SEC;
         if (step <= 0) begin
            step = 1;
         end
         if (step >= remain) begin
            nxt = goal;
         end else begin
            nxt = (goal > cur) ? cur + step : cur - step;
         end
      end
      ramp_fx = FIX_W'(nxt);
      cur = longint'(ramp_fx);
      if (fb == 0) begin
         rnd = cur;
      end else begin
         half = longint'(1) << (fb - 1);
         mag = (cur < 0) ? -cur : cur;
         rnd = (mag + half) >>> fb;
         if (cur < 0) begin
            rnd = -rnd;
         end
      end
      if (rnd < RAW_MIN) begin
         rnd = RAW_MIN;
      end
      if (rnd > RAW_MAX) begin
         rnd = RAW_MAX;
      end
      r.fixed = ramp_fx;
      r.raw = TGT_W'(rnd);
      r.active = (cur != goal);
      return r;
   endfunction

   always @(posedge clock) begin
      logic busy;
      busy = req_chan.valid;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            setpoint_q.push_back(next_setpoint(offered.target, offered.ms));
            ticks_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (tick_q.size() > 0 && gap_cnt >= tick_q[0].gap) begin
               offered = tick_q.pop_front();
               gap_cnt = 0;
               req_chan.valid <= 1'b1;
               req_chan.requested_target <= offered.target;
               req_chan.elapsed_ms <= offered.ms;
            end else begin
               if (tick_q.size() > 0) begin
                  gap_cnt++;
               end
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      setpoint_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_cnt = 0;
         stall_goal = 0;
         hold_cnt = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            setpoints_seen++;
            if (setpoint_q.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected beat, expected none, actual fixed %0d",
                        $time, rsp_chan.ramped_fixed);
               $display("%0t ns: unexpected beat, actual raw %0d active %0b",
                        $time, rsp_chan.ramped_raw, rsp_chan.ramp_active);
            end else begin
               want = setpoint_q.pop_front();
               if (rsp_chan.ramped_fixed !== want.fixed) begin
                  errors++;
                  $display("%0t ns: ramped_fixed expected %0d actual %0d",
                           $time, want.fixed, rsp_chan.ramped_fixed);
               end
               if (rsp_chan.ramped_raw !== want.raw) begin
                  errors++;
                  $display("%0t ns: ramped_raw expected %0d actual %0d",
                           $time, want.raw, rsp_chan.ramped_raw);
               end
               if (rsp_chan.ramp_active !== want.active) begin
                  errors++;
                  $display("%0t ns: ramp_active expected %0b actual %0b",
                           $time, want.active, rsp_chan.ramp_active);
               end
            end
            stall_cnt = 0;
            stall_goal = rsp_idle ? $urandom_range(0, GAP_MAX) : 0;
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_cnt < stall_goal) begin
            stall_cnt++;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic tick(input logic signed [TGT_W-1:0] target, input logic [MS_W-1:0] ms);
      tick_type t;
      t.target = target;
      t.ms = ms;
      t.gap = snd_idle ? $urandom_range(0, GAP_MAX) : 0;
      tick_q.push_back(t);
   endtask

   task automatic settle();
      do begin
         @(negedge clock);
      end while (tick_q.size() > 0 || req_chan.valid || setpoint_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SLEW_RATE) begin
         slew_cfg = data;
      end else begin
         frac_cfg = data[FRAC_W-1:0];
      end
      csr_writes++;
   endtask

   task automatic set_ramp(input logic [SLEW_W-1:0] slew, input logic [FRAC_W-1:0] frac);
      logic [CSR_DATA_W-1:0] data;
      settle();
      write_csr(CSR_SLEW_RATE, slew);
      data = CSR_DATA_W'($urandom);
      data[FRAC_W-1:0] = frac;
      write_csr(CSR_FRAC_BITS, data);
   endtask

   initial begin
      int unsigned p, n, k, i;
      logic signed [TGT_W-1:0] tgt;
      logic signed [TGT_W-1:0] last_tgt;
      logic [MS_W-1:0] ms;
      logic [SLEW_W-1:0] slew;
      logic [FRAC_W-1:0] frac;
      req_chan.valid = 1'b0;
      req_chan.requested_target = '0;
      req_chan.elapsed_ms = '0;
      rsp_chan.ready = 1'b0;
      slew_cfg = '0;
      frac_cfg = FRAC_RESET;
      ramp_fx = '0;
      last_tgt = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The slew rate is zero after reset, so the ramp must not move.
      tick(17'sd1000, 10'd100);
      tick(17'sd0, 10'd0);
      set_ramp(16'hFFFF, 4'd8);
      tick(17'sd65535, 10'd1023);
      // The stored ramp is read with no fraction, so the raw value saturates.
      set_ramp(16'hFFFF, 4'd0);
      tick(17'sd65535, 10'd0);
      set_ramp(16'hFFFF, 4'd8);
      tick(-17'sd65536, 10'd1023);
      tick(-17'sd65536, 10'd0);
      tick(-17'sd65536, 10'd1023);
      set_ramp(16'hFFFF, 4'd0);
      tick(-17'sd65536, 10'd0);
      tick(17'sd65535, 10'd1);
      // Fraction widths above the maximum behave as the maximum.
      set_ramp(16'hFFFF, 4'd15);
      tick(17'sd0, 10'd1023);
      set_ramp(16'd1, 4'd8);
      tick(17'sd1, 10'd500);
      tick(-17'sd1, 10'd500);
      tick(-17'sd1, 10'd500);
      tick(-17'sd1, 10'd1);
      // A value exactly half way between raw units rounds away from zero.
      set_ramp(16'd1, 4'd1);
      tick(17'sd0, 10'd0);
      tick(-17'sd64, 10'd500);
      last_tgt = -17'sd64;

      for (p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 9))
            0: slew = '0;
            1: slew = 16'hFFFF;
            default: slew = SLEW_W'($urandom_range(0, (1 << $urandom_range(1, SLEW_W)) - 1));
         endcase
         frac = FRAC_W'(($urandom_range(0, 3) == 0) ? $urandom_range(FRAC_MAX + 1, 15)
                                                    : $urandom_range(0, FRAC_MAX));
         set_ramp(slew, frac);
         snd_idle = (p % 4 == 0) || (p % 4 == 2);
         rsp_idle = (p % 4 == 0) || (p % 4 == 3);
         if (p == 5) begin
            snd_idle = 1'b0;
            hold_token++;
         end
         n = 0;
         while (n < TICKS_PER_PHASE) begin
            case ($urandom_range(0, 3))
               0: begin
                  case ($urandom_range(0, 4))
                     0: tgt = -17'sd65536;
                     1: tgt = 17'sd65535;
                     2: tgt = 17'sd0;
                     3: tgt = 17'sd1;
                     default: tgt = -17'sd1;
                  endcase
               end
               1: tgt = last_tgt + TGT_W'($urandom_range(0, 64)) - 17'sd32;
               default: tgt = TGT_W'($urandom);
            endcase
            last_tgt = tgt;
            k = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : 1;
            for (i = 0; i < k; i++) begin
               case ($urandom_range(0, 5))
                  0: ms = '0;
                  1: ms = 10'd1023;
                  2: ms = MS_W'($urandom_range(1, 20));
                  default: ms = MS_W'($urandom);
               endcase
               tick(tgt, ms);
               n++;
            end
         end
      end

      settle();
      $display("Summary: %0d ticks sent, %0d setpoints checked, %0d register writes.",
               ticks_sent, setpoints_seen, csr_writes);
      $display("Covered zero and full slew, fraction widths 0 to 15 and a long output stall.");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* setpoint_ramp_generator_top.f */
rtl/srg_pkg.sv
rtl/srg_if.sv
rtl/setpoint_ramp_generator_top.sv
tb/sv/tb.sv
